FILE: src/smpq_pkg.sv
package smpq_pkg;

    localparam int DEF_CAPACITY   = 16;
    localparam int DEF_DATA_WIDTH = 32;

    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 5;
    localparam int STATUS_W = 2;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_POP_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_PUSH_FULL = 2'd2;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_REJECT_EMPTY,
        OP_REJECT_FULL,
        OP_PUSH_FIRST,
        OP_PUSH_INIT,
        OP_PUSH_STEP,
        OP_POP_LAST,
        OP_POP_INIT,
        OP_POP_STEP
    } t_dp_op;

    typedef struct packed {
        logic cmd_pop;
        logic empty;
        logic full;
        logic single;
        logic push_stop;
        logic pop_last;
    } t_dp_flags;

endpackage

FILE: src/smpq_datapath.sv
module smpq_datapath import smpq_pkg::*; #(
    parameter int CAPACITY   = DEF_CAPACITY,
    parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_dp_op                     i_op,
    input  logic                       i_command,
    input  logic signed [VALUE_W-1:0]  i_value,
    output t_dp_flags                  o_flags,
    output logic signed [VALUE_W-1:0]  o_top_value,
    output logic [COUNT_W-1:0]         o_count,
    output logic                       o_is_empty,
    output logic                       o_is_full,
    output logic [STATUS_W-1:0]        o_status
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic signed [DATA_WIDTH-1:0] r_mem [CAPACITY];
    logic signed [DATA_WIDTH-1:0] r_rdata;
    logic signed [DATA_WIDTH-1:0] r_key;
    logic signed [DATA_WIDTH-1:0] r_top;
    logic signed [DATA_WIDTH-1:0] n_top;
    logic                         r_cmd;
    logic [CW-1:0]                r_count;
    logic [CW-1:0]                n_count;
    logic [IW-1:0]                r_ptr;
    logic [IW-1:0]                n_ptr;
    logic [STATUS_W-1:0]          r_status;
    logic [STATUS_W-1:0]          n_status;

    logic                         rd_en;
    logic [IW-1:0]                rd_addr;
    logic                         wr_en;
    logic [IW-1:0]                wr_addr;
    logic signed [DATA_WIDTH-1:0] wr_data;

    logic                         empty;
    logic                         push_stop;
    logic                         pop_last;

    assign empty     = (r_count == '0);
    assign push_stop = (r_ptr == '0) || (r_rdata > r_key);
    assign pop_last  = ((CW'(r_ptr) + CW'(2)) == r_count);

    assign o_flags.cmd_pop   = (r_cmd == CMD_POP);
    assign o_flags.empty     = empty;
    assign o_flags.full      = (r_count == CW'(CAPACITY));
    assign o_flags.single    = (r_count == CW'(1));
    assign o_flags.push_stop = push_stop;
    assign o_flags.pop_last  = pop_last;

    always_comb begin
        rd_en    = 1'b0;
        rd_addr  = '0;
        wr_en    = 1'b0;
        wr_addr  = '0;
        wr_data  = r_key;
        n_count  = r_count;
        n_ptr    = r_ptr;
        n_top    = r_top;
        n_status = r_status;
        unique case (i_op)
            OP_NONE, OP_LOAD: begin
            end
            OP_REJECT_EMPTY: begin
                n_status = ST_POP_EMPTY;
            end
            OP_REJECT_FULL: begin
                n_status = ST_PUSH_FULL;
            end
            OP_PUSH_FIRST: begin
                wr_en    = 1'b1;
                n_top    = r_key;
                n_count  = r_count + CW'(1);
                n_status = ST_OK;
            end
            OP_PUSH_INIT: begin
                rd_en   = 1'b1;
                rd_addr = IW'(r_count - CW'(1));
                n_ptr   = IW'(r_count);
                if (r_key >= r_top) begin
                    n_top = r_key;
                end
            end
            OP_PUSH_STEP: begin
                wr_en   = 1'b1;
                wr_addr = r_ptr;
                if (push_stop) begin
                    n_count  = r_count + CW'(1);
                    n_status = ST_OK;
                end else begin
                    wr_data = r_rdata;
                    n_ptr   = r_ptr - IW'(1);
                    rd_en   = 1'b1;
                    rd_addr = r_ptr - IW'(2);
                end
            end
            OP_POP_LAST: begin
                n_count  = r_count - CW'(1);
                n_status = ST_OK;
            end
            OP_POP_INIT: begin
                rd_en   = 1'b1;
                rd_addr = IW'(1);
                n_ptr   = '0;
            end
            OP_POP_STEP: begin
                wr_en   = 1'b1;
                wr_addr = r_ptr;
                wr_data = r_rdata;
                if (r_ptr == '0) begin
                    n_top = r_rdata;
                end
                if (pop_last) begin
                    n_count  = r_count - CW'(1);
                    n_status = ST_OK;
                end else begin
                    n_ptr   = r_ptr + IW'(1);
                    rd_en   = 1'b1;
                    rd_addr = r_ptr + IW'(2);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_op == OP_LOAD) begin
            r_cmd <= i_command;
            r_key <= DATA_WIDTH'(i_value);
        end
        r_ptr    <= n_ptr;
        r_top    <= n_top;
        r_status <= n_status;
    end

    assign o_top_value = empty ? '0 : VALUE_W'(r_top);
    assign o_count     = COUNT_W'(r_count);
    assign o_is_empty  = empty;
    assign o_is_full   = o_flags.full;
    assign o_status    = r_status;

endmodule

FILE: src/smpq_ctrl.sv
module smpq_ctrl import smpq_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    input  t_dp_flags i_flags,
    output t_dp_op    o_op,
    output logic      busy,
    output logic      o_valid
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DISPATCH,
        S_PUSH,
        S_POP
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_valid;
    logic   n_valid;

    always_comb begin
        o_op    = OP_NONE;
        n_state = r_state;
        n_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_op    = OP_LOAD;
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                priority if (i_flags.cmd_pop && i_flags.empty) begin
                    o_op    = OP_REJECT_EMPTY;
                    n_state = S_IDLE;
                    n_valid = 1'b1;
                end else if (i_flags.cmd_pop && i_flags.single) begin
                    o_op    = OP_POP_LAST;
                    n_state = S_IDLE;
                    n_valid = 1'b1;
                end else if (i_flags.cmd_pop) begin
                    o_op    = OP_POP_INIT;
                    n_state = S_POP;
                end else if (i_flags.full) begin
                    o_op    = OP_REJECT_FULL;
                    n_state = S_IDLE;
                    n_valid = 1'b1;
                end else if (i_flags.empty) begin
                    o_op    = OP_PUSH_FIRST;
                    n_state = S_IDLE;
                    n_valid = 1'b1;
                end else begin
                    o_op    = OP_PUSH_INIT;
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                o_op = OP_PUSH_STEP;
                if (i_flags.push_stop) begin
                    n_state = S_IDLE;
                    n_valid = 1'b1;
                end
            end
            S_POP: begin
                o_op = OP_POP_STEP;
                if (i_flags.pop_last) begin
                    n_state = S_IDLE;
                    n_valid = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_valid;

endmodule

FILE: src/sorted_max_priority_queue_core.sv
// Channel   Direction  Handshake              Fields
// command   in         start & !busy          i_command, i_value
// result    out        o_valid, one cycle     o_top_value, o_count, o_is_empty,
//                                             o_is_full, o_status
//
// A push holds busy while it shifts entries down, a pop while it moves the remaining
// entries up, one entry per step through the store's one write port; a push into an
// empty queue, a pop of the last entry and a dropped or ignored item finish in the
// dispatch state.
// The result strobes in the cycle busy drops; start may be taken in that cycle.
// Reset empties the queue at once. The receiver cannot stall; each result is shown
// for one cycle only.
module sorted_max_priority_queue_core import smpq_pkg::*; #(
    parameter int CAPACITY   = DEF_CAPACITY,
    parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       i_command,
    input  logic signed [VALUE_W-1:0]  i_value,
    output logic                       o_valid,
    output logic signed [VALUE_W-1:0]  o_top_value,
    output logic [COUNT_W-1:0]         o_count,
    output logic                       o_is_empty,
    output logic                       o_is_full,
    output logic [STATUS_W-1:0]        o_status
);

    t_dp_op    op;
    t_dp_flags flags;

    smpq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_flags (flags),
        .o_op    (op),
        .busy    (busy),
        .o_valid (o_valid)
    );

    smpq_datapath #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (op),
        .i_command   (i_command),
        .i_value     (i_value),
        .o_flags     (flags),
        .o_top_value (o_top_value),
        .o_count     (o_count),
        .o_is_empty  (o_is_empty),
        .o_is_full   (o_is_full),
        .o_status    (o_status)
    );

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while still busy");

    a_full_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_PUSH_FULL) |-> o_is_full)
        else $error("push dropped on a queue that is not full");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_POP_EMPTY) |-> (o_is_empty && o_top_value == '0))
        else $error("pop ignored on a queue that is not empty");

    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_is_empty |-> !o_is_full)
        else $error("queue flagged both empty and full");

endmodule
